// ----- hdl/extent_map_translate_core_assert.svh -----
// Assertion macros for the extent map translator
`ifndef EXTENT_MAP_TRANSLATE_CORE_ASSERT_SVH
`define EXTENT_MAP_TRANSLATE_CORE_ASSERT_SVH
// Check that a property holds on every clock edge out of reset
`define EMT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Check an implication from an antecedent to a consequent in the next cycle
`define EMT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ----- hdl/emt_pkg.sv -----
package emt_pkg;
	localparam logic [1:0] KIND_ADD    = 2'd0;
	localparam logic [1:0] KIND_FIND   = 2'd1;
	localparam logic [1:0] KIND_CLEAR  = 2'd2;
	localparam logic [1:0] KIND_UNUSED = 2'd3;

	localparam logic [2:0] ST_ADDED   = 3'd0;
	localparam logic [2:0] ST_ZERO    = 3'd1;
	localparam logic [2:0] ST_FULL    = 3'd2;
	localparam logic [2:0] ST_FOUND   = 3'd3;
	localparam logic [2:0] ST_MISS    = 3'd4;
	localparam logic [2:0] ST_CLEARED = 3'd5;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] start_block;
		logic [31:0] block_count;
		logic [37:0] logical_blk;
	} emt_in_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [32:0] physical_block;
		logic [31:0] run_length;
	} emt_out_t;

	// one table row: physical start, length, logical start
	typedef struct packed {
		logic [31:0] phys;
		logic [31:0] len;
		logic [37:0] lstart;
	} emt_entry_t;
endpackage

// ----- hdl/emt_ram.sv -----
module emt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ----- hdl/extent_map_translate_core.sv -----
// Channel | Dir | Handshake           | Payload
// in      | in  | in_valid/in_ready   | emt_in_t (kind, start_block, block_count, logical_blk)
// out     | out | out_valid/out_ready | emt_out_t (status, physical_block, run_length)
// One item at a time. Find reads and compares each entry in turn (S_FDR, S_FDC) until a hit
// or the last entry. Add shifts up one place each row whose physical start is at or above
// the new start, writes the new row in the gap, then rewrites every logical start in order.
// Clear and zero or full adds skip the table. Reset clears the fill count, not the RAM.
// A stalled result holds in the output register; no new item enters until taken.
module extent_map_translate_core
	import emt_pkg::*;
#(
	parameter int MAX_EXTENTS = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  emt_in_t  in,
	output logic     out_valid,
	input  logic     out_ready,
	output emt_out_t out
);
	localparam int AW = $clog2(MAX_EXTENTS);
	localparam int CW = $clog2(MAX_EXTENTS + 1);
	localparam int EW = $bits(emt_entry_t);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SHR  = 3'd1; // shift read issued
	localparam logic [2:0] S_SHW  = 3'd2; // compare and shift
	localparam logic [2:0] S_LBR  = 3'd3; // relabel read
	localparam logic [2:0] S_LBW  = 3'd4; // relabel write
	localparam logic [2:0] S_FDR  = 3'd5; // find read
	localparam logic [2:0] S_FDC  = 3'd6; // find compare
	localparam logic [2:0] S_OUT  = 3'd7;

	logic [2:0]    state_q;
	logic [CW-1:0] used_q;
	logic [CW-1:0] idx_q;
	logic [37:0]   sum_q;
	emt_in_t       item_q;
	emt_out_t      res_q;

	logic          we;
	logic [AW-1:0] waddr, raddr;
	emt_entry_t    wdata, rdata;
	logic [CW-1:0] idx_dec;

	emt_ram #(.WIDTH(EW), .DEPTH(MAX_EXTENTS)) u_table (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	// result with a status and no translation
	function automatic emt_out_t status_res(input logic [2:0] st);
		return '{status: st, physical_block: 33'd0, run_length: 32'd0};
	endfunction

	logic [37:0] off;
	logic        hit;
	assign off = item_q.logical_blk - rdata.lstart;
	assign hit = (item_q.logical_blk >= rdata.lstart) && (off < {6'd0, rdata.len});
	assign idx_dec = idx_q - CW'(1);

	// memory control per state
	always_comb begin
		we    = 1'b0;
		waddr = idx_q[AW-1:0];
		wdata = rdata;
		raddr = idx_q[AW-1:0];
		case (state_q)
			S_SHR: begin
				raddr = idx_dec[AW-1:0];
			end
			S_SHW: begin
				we = 1'b1;
				if (idx_q != '0 && rdata.phys >= item_q.start_block) begin
					wdata = rdata;
				end else begin
					wdata = '{phys: item_q.start_block, len: item_q.block_count,
						lstart: 38'd0};
				end
			end
			S_LBW: begin
				we    = 1'b1;
				wdata = '{phys: rdata.phys, len: rdata.len, lstart: sum_q};
			end
			default: ;
		endcase
	end

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out       = res_q;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q  <= '0;
			idx_q   <= '0;
			sum_q   <= '0;
			item_q  <= '0;
			res_q   <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						item_q <= in;
						case (in.kind)
							KIND_ADD: begin
								if (in.block_count == '0) begin
									res_q   <= status_res(ST_ZERO);
									state_q <= S_OUT;
								end else if (used_q == CW'(MAX_EXTENTS)) begin
									res_q   <= status_res(ST_FULL);
									state_q <= S_OUT;
								end else begin
									res_q   <= status_res(ST_ADDED);
									idx_q   <= used_q;
									state_q <= S_SHR;
								end
							end
							KIND_FIND: begin
								res_q   <= status_res(ST_MISS);
								idx_q   <= '0;
								state_q <= (used_q != '0) ? S_FDR : S_OUT;
							end
							KIND_CLEAR: begin
								used_q  <= '0;
								res_q   <= status_res(ST_CLEARED);
								state_q <= S_OUT;
							end
							default: begin
								res_q   <= status_res(ST_MISS);
								state_q <= S_OUT;
							end
						endcase
					end
				end
				S_SHR: begin
					state_q <= S_SHW;
				end
				S_SHW: begin
					// shift the row up, or drop the new row and start relabel
					if (idx_q != '0 && rdata.phys >= item_q.start_block) begin
						idx_q   <= idx_dec;
						state_q <= S_SHR;
					end else begin
						used_q  <= used_q + CW'(1);
						idx_q   <= '0;
						sum_q   <= '0;
						state_q <= S_LBR;
					end
				end
				S_LBR: begin
					state_q <= S_LBW;
				end
				S_LBW: begin
					sum_q <= sum_q + {6'd0, rdata.len};
					if (idx_q + CW'(1) >= used_q) begin
						state_q <= S_OUT;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_LBR;
					end
				end
				S_FDR: begin
					state_q <= S_FDC;
				end
				S_FDC: begin
					if (hit) begin
						res_q <= '{status: ST_FOUND,
							physical_block: {1'b0, rdata.phys} + off[32:0],
							run_length: rdata.len - off[31:0]};
						state_q <= S_OUT;
					end else if (idx_q + CW'(1) >= used_q) begin
						state_q <= S_OUT;
					end else begin
						idx_q   <= idx_q + CW'(1);
						state_q <= S_FDR;
					end
				end
				S_OUT: begin
					if (out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`include "extent_map_translate_core_assert.svh"

	`EMT_ASSERT(a_used_bound, used_q <= CW'(MAX_EXTENTS), "fill count beyond table depth")
	`EMT_ASSERT(a_ready_excl, !(in_ready && out_valid), "input taken while result pending")
	`EMT_ASSERT_NEXT(a_found_run, out_valid && out.status == ST_FOUND,
		!out_valid || out.run_length != '0, "found result with zero run")
endmodule
